@@ src/tcf_pkg.sv @@
`default_nettype none
package tcf_pkg;

  // angle format
  localparam int ANGLE_FRAC_BITS = 10;
  localparam int ANG_W = 20;
  localparam int GYRO_SHIFT = ANGLE_FRAC_BITS - 6;

  // shared multiplier operands
  localparam int MUL_A_W = 19;
  localparam int MUL_B_W = 39;
  localparam int PROD_W = MUL_A_W + MUL_B_W;

  // shared divider
  localparam int DVD_W = 54;
  localparam int DVS_W = 20;
  localparam int DIV_CNT_W = 6;

  // config
  localparam int W_W = 17;
  localparam int TPS_W = 20;
  localparam logic [W_W-1:0] W_RESET = 17'd64225;
  localparam logic [W_W-1:0] W_ONE = 17'd65536;
  localparam logic [TPS_W-1:0] TPS_RESET = 20'd1000;
  localparam logic CFG_IDX_WEIGHT = 1'b0;
  localparam logic CFG_IDX_TPS = 1'b1;

  // arctangent polynomial and radian-to-degree scale, Q16
  localparam logic [MUL_B_W-1:0] K_C3 = 39'd3047;
  localparam logic [PROD_W-1:0] K_C2_Q32 = 58'd10441 << 16;
  localparam logic [PROD_W-1:0] K_C1_Q32 = 58'd21471 << 16;
  localparam logic [MUL_B_W-1:0] K_DEG = 39'd3754936;

  localparam logic signed [ANG_W-1:0] DEG_90 = 20'sd90 <<< ANGLE_FRAC_BITS;
  localparam logic signed [ANG_W-1:0] DEG_180 = 20'sd180 <<< ANGLE_FRAC_BITS;
  localparam logic signed [ANG_W-1:0] DEG_360 = 20'sd360 <<< ANGLE_FRAC_BITS;

  // predicted angle clamp: large enough that the blend saturates whenever the filter weight is nonzero
  localparam logic [MUL_B_W-1:0] Q_LIM = 39'd1 << 38;
  localparam logic signed [MUL_B_W+1:0] G_LIM = 41'sd1 <<< 37;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIVA,
    ST_MUL,
    ST_WB,
    ST_DIVG,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_SQ,
    OP_U,
    OP_V,
    OP_T1,
    OP_T,
    OP_DEG,
    OP_GYRO,
    OP_WG,
    OP_WA
  } op_t;

endpackage
`default_nettype wire

@@ src/tcf_div.sv @@
`default_nettype none
module tcf_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [tcf_pkg::DVD_W-1:0]   dividend,
  input  wire logic [tcf_pkg::DVS_W-1:0]   divisor,
  output logic                             done,
  output logic [tcf_pkg::DVD_W-1:0]        quotient
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [tcf_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [tcf_pkg::DVD_W-1:0]     quo_r, quo_nxt;
  logic [tcf_pkg::DVS_W-1:0]     rem_r, rem_nxt;
  logic [tcf_pkg::DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [tcf_pkg::DVS_W:0]       sh;
  logic                          ge;

  // restoring divide, one quotient bit per cycle
  always_comb begin
    sh = {rem_r, quo_r[tcf_pkg::DVD_W-1]};
    ge = (sh >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = tcf_pkg::DIV_CNT_W'(tcf_pkg::DVD_W - 1);
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? tcf_pkg::DVS_W'(sh - {1'b0, dvs_r}) : sh[tcf_pkg::DVS_W-1:0];
      quo_nxt = {quo_r[tcf_pkg::DVD_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

@@ src/tilt_complementary_filter.sv @@
`default_nettype none
// Complementary tilt filter for one IMU sample per request. Each request runs
// three axes one after another through one shared multiplier and one radix-2
// divider under a small sequencer; the block takes no new request until the
// result is in the output register. Per axis: a setup step, a divide for the
// arctangent ratio, seven multiplies, a divide for the gyro step and two more
// multiplies. An axis whose accelerometer pair is all zero skips the ratio
// divide and the polynomial. The output register load waits for out_ready
// while an earlier result is still held there. filter_weight (addr 0)
// and the tick rate (addr 4) sit on the APB port; write them only while no
// request is in flight.
module tilt_complementary_filter (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [31:0]        in_tick,
  input  wire logic signed [15:0] in_accel_x,
  input  wire logic signed [15:0] in_accel_y,
  input  wire logic signed [15:0] in_accel_z,
  input  wire logic signed [17:0] in_rate_x,
  input  wire logic signed [17:0] in_rate_y,
  input  wire logic signed [17:0] in_rate_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [19:0]      out_angle_x,
  output logic signed [19:0]      out_angle_y,
  output logic signed [19:0]      out_angle_z,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [2:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  localparam int AW = tcf_pkg::ANG_W;
  localparam int PW = tcf_pkg::PROD_W;
  localparam int BW = tcf_pkg::MUL_B_W;
  localparam logic signed [BW+1:0] G_LIM_S = tcf_pkg::G_LIM;

  // config registers
  logic [tcf_pkg::W_W-1:0]   fw_r;
  logic [tcf_pkg::TPS_W-1:0] tps_r;
  logic                      cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= tcf_pkg::W_RESET;
      tps_r <= tcf_pkg::TPS_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == tcf_pkg::CFG_IDX_WEIGHT) fw_r <= cfg_pwdata[tcf_pkg::W_W-1:0];
      else tps_r <= cfg_pwdata[tcf_pkg::TPS_W-1:0];
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      tcf_pkg::CFG_IDX_WEIGHT: cfg_prdata = {15'd0, fw_r};
      tcf_pkg::CFG_IDX_TPS:    cfg_prdata = {12'd0, tps_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  // sequencer state and datapath registers
  tcf_pkg::state_t state_r, state_nxt;
  tcf_pkg::op_t    op_r, op_nxt;
  logic [1:0]      axis_r, axis_nxt;
  logic [31:0]     last_tick_r;
  logic [31:0]     dticks_r;
  logic signed [15:0] ax_r, ay_r, az_r;
  logic signed [17:0] rx_r, ry_r, rz_r;
  logic signed [AW-1:0] ang_r [3];
  logic [16:0]     a_r, a_nxt;
  logic [16:0]     s_r, s_nxt;
  logic signed [BW-1:0] wk_r, wk_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [PW-1:0] sum_r, sum_nxt;
  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] res_nxt;
  logic            res_we;
  logic            out_valid_r, out_valid_nxt, out_load;
  logic signed [AW-1:0] out_x_r, out_y_r, out_z_r;
  logic            in_acc;

  assign in_ready = (state_r == tcf_pkg::ST_IDLE);
  assign in_acc = in_valid & in_ready;

  // operand pair for the current axis
  logic signed [15:0] first, second;
  logic [16:0] mag_f, mag_s, mx, mn;
  logic        s_gt_f;
  always_comb begin
    first = (axis_r == 2'd0) ? ay_r : ax_r;
    second = (axis_r == 2'd2) ? ay_r : az_r;
    mag_f = first[15] ? 17'(-{first[15], first}) : {1'b0, first};
    mag_s = second[15] ? 17'(-{second[15], second}) : {1'b0, second};
    s_gt_f = (mag_s > mag_f);
    mx = s_gt_f ? mag_s : mag_f;
    mn = s_gt_f ? mag_f : mag_s;
  end

  // gyro rate for the current axis, x and z negated
  logic signed [18:0] rate_eff;
  logic [17:0]        rate_mag;
  always_comb begin
    case (axis_r)
      2'd0:    rate_eff = -19'(rx_r);
      2'd1:    rate_eff = 19'(ry_r);
      default: rate_eff = -19'(rz_r);
    endcase
    rate_mag = rate_eff[18] ? 18'(-rate_eff) : 18'(rate_eff);
  end

  logic [tcf_pkg::W_W-1:0]   w_eff, w_inv;
  logic [tcf_pkg::TPS_W-1:0] tps_eff;
  assign w_eff = (fw_r > tcf_pkg::W_ONE) ? tcf_pkg::W_ONE : fw_r;
  assign w_inv = tcf_pkg::W_ONE - w_eff;
  assign tps_eff = (tps_r == '0) ? tcf_pkg::TPS_W'(1) : tps_r;

  // shared multiplier, product registered
  logic signed [tcf_pkg::MUL_A_W-1:0] mul_a;
  logic signed [BW-1:0]               mul_b;
  always_comb begin
    case (op_r)
      tcf_pkg::OP_SQ:   begin mul_a = {2'b0, a_r}; mul_b = {22'd0, a_r}; end
      tcf_pkg::OP_U:    begin mul_a = {2'b0, s_r}; mul_b = tcf_pkg::K_C3; end
      tcf_pkg::OP_V:    begin mul_a = {2'b0, s_r}; mul_b = wk_r; end
      tcf_pkg::OP_T1:   begin mul_a = {2'b0, s_r}; mul_b = wk_r; end
      tcf_pkg::OP_T:    begin mul_a = {2'b0, a_r}; mul_b = wk_r; end
      tcf_pkg::OP_DEG:  begin mul_a = {2'b0, a_r}; mul_b = tcf_pkg::K_DEG; end
      tcf_pkg::OP_GYRO: begin mul_a = {1'b0, rate_mag}; mul_b = {7'd0, dticks_r}; end
      tcf_pkg::OP_WG:   begin mul_a = {2'b0, w_eff}; mul_b = wk_r; end
      tcf_pkg::OP_WA:   begin mul_a = {2'b0, w_inv}; mul_b = BW'(acc_r); end
      default:          begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == tcf_pkg::ST_MUL) prod_r <= mul_a * mul_b;
  end

  // divider
  logic                       div_start;
  logic [tcf_pkg::DVD_W-1:0]  div_dvd;
  logic [tcf_pkg::DVS_W-1:0]  div_dvs;
  logic                       div_done;
  logic [tcf_pkg::DVD_W-1:0]  div_q;

  tcf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // rounding helpers on the product
  logic signed [PW-1:0] p_rnd, p_u, p_v, p_deg, num;
  logic [16:0]          d_deg;
  logic signed [AW-1:0] deg0, deg1, deg2;
  logic [BW-1:0]        qc;
  logic signed [BW+1:0] g_full;
  logic signed [PW-1:0] num_rnd;
  logic signed [PW-17:0] res_full;

  always_comb begin
    p_rnd = prod_r + PW'(32768);
    p_u = $signed(tcf_pkg::K_C2_Q32) - prod_r + PW'(32768);
    p_v = $signed(tcf_pkg::K_C1_Q32) - prod_r + PW'(32768);
    p_deg = prod_r + (PW'(1) <<< (31 - tcf_pkg::ANGLE_FRAC_BITS));
    d_deg = p_deg[32-tcf_pkg::ANGLE_FRAC_BITS +: 17];
    deg0 = {3'b0, d_deg};
    deg1 = s_gt_f ? tcf_pkg::DEG_90 - deg0 : deg0;
    deg2 = first[15] ? tcf_pkg::DEG_180 - deg1 : deg1;
    // gyro step, clamped, added to previous angle
    qc = (div_q > tcf_pkg::DVD_W'(tcf_pkg::Q_LIM)) ? tcf_pkg::Q_LIM : div_q[BW-1:0];
    g_full = rate_eff[18] ? (BW+2)'(ang_r[axis_r]) - (BW+2)'(qc)
                          : (BW+2)'(ang_r[axis_r]) + (BW+2)'(qc);
    // blend and round
    num = sum_r + prod_r;
    num_rnd = num + PW'(32768);
    res_full = num_rnd[PW-1:16];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    axis_nxt = axis_r;
    a_nxt = a_r;
    s_nxt = s_r;
    wk_nxt = wk_r;
    acc_nxt = acc_r;
    sum_nxt = sum_r;
    res_nxt = '0;
    res_we = 1'b0;
    div_start = 1'b0;
    div_dvd = {5'd0, mn, 16'd0} + tcf_pkg::DVD_W'(mx[16:1]);
    div_dvs = tcf_pkg::DVS_W'(mx);
    out_load = 1'b0;
    case (state_r)
      tcf_pkg::ST_IDLE: begin
        if (in_acc) begin
          axis_nxt = 2'd0;
          state_nxt = tcf_pkg::ST_SETUP;
        end
      end
      tcf_pkg::ST_SETUP: begin
        if (mx == '0) begin
          acc_nxt = '0;
          op_nxt = tcf_pkg::OP_GYRO;
          state_nxt = tcf_pkg::ST_MUL;
        end else begin
          div_start = 1'b1;
          state_nxt = tcf_pkg::ST_DIVA;
        end
      end
      tcf_pkg::ST_DIVA: begin
        if (div_done) begin
          a_nxt = div_q[16:0];
          op_nxt = tcf_pkg::OP_SQ;
          state_nxt = tcf_pkg::ST_MUL;
        end
      end
      tcf_pkg::ST_MUL: state_nxt = tcf_pkg::ST_WB;
      tcf_pkg::ST_WB: begin
        state_nxt = tcf_pkg::ST_MUL;
        case (op_r)
          tcf_pkg::OP_SQ: begin
            s_nxt = p_rnd[32:16];
            op_nxt = tcf_pkg::OP_U;
          end
          tcf_pkg::OP_U: begin
            wk_nxt = p_u[BW+15:16];
            op_nxt = tcf_pkg::OP_V;
          end
          tcf_pkg::OP_V: begin
            wk_nxt = p_v[BW+15:16];
            op_nxt = tcf_pkg::OP_T1;
          end
          tcf_pkg::OP_T1: begin
            wk_nxt = p_rnd[BW+15:16];
            op_nxt = tcf_pkg::OP_T;
          end
          tcf_pkg::OP_T: begin
            a_nxt = a_r - p_rnd[32:16];
            op_nxt = tcf_pkg::OP_DEG;
          end
          tcf_pkg::OP_DEG: begin
            acc_nxt = second[15] ? -deg2 : deg2;
            op_nxt = tcf_pkg::OP_GYRO;
          end
          tcf_pkg::OP_GYRO: begin
            div_start = 1'b1;
            div_dvd = {prod_r[49:0], tcf_pkg::GYRO_SHIFT'(0)} +
                      tcf_pkg::DVD_W'(tps_eff[tcf_pkg::TPS_W-1:1]);
            div_dvs = tps_eff;
            state_nxt = tcf_pkg::ST_DIVG;
          end
          tcf_pkg::OP_WG: begin
            sum_nxt = prod_r;
            op_nxt = tcf_pkg::OP_WA;
          end
          tcf_pkg::OP_WA: begin
            res_we = 1'b1;
            if (res_full > (PW-16)'(tcf_pkg::DEG_360)) res_nxt = tcf_pkg::DEG_360;
            else if (res_full < -(PW-16)'(tcf_pkg::DEG_360)) res_nxt = -tcf_pkg::DEG_360;
            else res_nxt = res_full[AW-1:0];
            if (axis_r == 2'd2) begin
              state_nxt = tcf_pkg::ST_OUT;
            end else begin
              axis_nxt = axis_r + 2'd1;
              state_nxt = tcf_pkg::ST_SETUP;
            end
          end
          default: state_nxt = tcf_pkg::ST_IDLE;
        endcase
      end
      tcf_pkg::ST_DIVG: begin
        if (div_done) begin
          if (g_full > G_LIM_S) wk_nxt = BW'(tcf_pkg::G_LIM);
          else if (g_full < -G_LIM_S) wk_nxt = BW'(-tcf_pkg::G_LIM);
          else wk_nxt = g_full[BW-1:0];
          op_nxt = tcf_pkg::OP_WG;
          state_nxt = tcf_pkg::ST_MUL;
        end
      end
      tcf_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          state_nxt = tcf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tcf_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcf_pkg::ST_IDLE;
      op_r <= tcf_pkg::OP_SQ;
      axis_r <= 2'd0;
      out_valid_r <= 1'b0;
      last_tick_r <= '0;
      ang_r[0] <= '0;
      ang_r[1] <= '0;
      ang_r[2] <= '0;
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
      axis_r <= axis_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) last_tick_r <= in_tick;
      if (res_we) ang_r[axis_r] <= res_nxt;
    end
    a_r <= a_nxt;
    s_r <= s_nxt;
    wk_r <= wk_nxt;
    acc_r <= acc_nxt;
    sum_r <= sum_nxt;
    if (in_acc) begin
      dticks_r <= in_tick - last_tick_r;
      ax_r <= in_accel_x;
      ay_r <= in_accel_y;
      az_r <= in_accel_z;
      rx_r <= in_rate_x;
      ry_r <= in_rate_y;
      rz_r <= in_rate_z;
    end
    if (out_load) begin
      out_x_r <= ang_r[0];
      out_y_r <= ang_r[1];
      out_z_r <= ang_r[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_angle_x = out_x_r;
  assign out_angle_y = out_y_r;
  assign out_angle_z = out_z_r;

  // a request holds the block busy for at least the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready) else $error("ready right after a request");

  // divider results only land in the states that wait for them
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == tcf_pkg::ST_DIVA || state_r == tcf_pkg::ST_DIVG))
    else $error("divider done outside a divide wait");

  // stored angles stay inside the saturation range
  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_we |=> (ang_r[0] <= tcf_pkg::DEG_360 && ang_r[0] >= -tcf_pkg::DEG_360 &&
                ang_r[1] <= tcf_pkg::DEG_360 && ang_r[1] >= -tcf_pkg::DEG_360 &&
                ang_r[2] <= tcf_pkg::DEG_360 && ang_r[2] >= -tcf_pkg::DEG_360))
    else $error("angle outside saturation range");

endmodule
`default_nettype wire
